### sv/glyph_quad_vertex_emitter_unit_assert.svh
// ----------------------------------------------------------------------------
// glyph_quad_vertex_emitter_unit assertion macros
// Concurrent assertion shorthands for the glyph quad emitter.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_VERTEX_EMITTER_UNIT_ASSERT_SVH
`define GLYPH_QUAD_VERTEX_EMITTER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define GQV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gqv assertion failed");

// next-cycle implication, active during reset
`define GQV_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gqv assertion failed");

`endif

### sv/gqv_pkg.sv
// ----------------------------------------------------------------------------
// gqv_pkg
// Shared types, constants and helpers of the glyph quad vertex emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gqv_pkg;

  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_IDX_W = ($clog2(GLYPH_COUNT) > 0) ? $clog2(GLYPH_COUNT) : 1;

  localparam int CODE_W    = 8;
  localparam int TEX_W     = 16;
  localparam int GWIDTH_W  = 8;
  localparam int XSTEP_W   = 21;
  localparam int HEIGHT_W  = 26;
  localparam int POS_W     = 32;
  localparam int SIZE_W    = GWIDTH_W + XSTEP_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = HEIGHT_W;

  localparam logic [CODE_W-1:0]   FIRST_CODE  = 8'd32;
  localparam logic [CODE_W-1:0]   LAST_CODE   = 8'd126;
  localparam logic [CODE_W-1:0]   COUNT_CODE  = CODE_W'(GLYPH_COUNT);
  localparam logic [GWIDTH_W-1:0] SPACE_MUL   = 8'd2;
  localparam logic [POS_W-1:0]    PEN_MAX     = 32'hFFFF_FFFF;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 26'h200_0000;
  localparam logic [XSTEP_W-1:0]  XSTEP_RST   = 21'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = 26'd32768;

  localparam int VTX_PER_QUAD = 6;
  localparam int VTX_CNT_W    = $clog2(VTX_PER_QUAD);
  localparam logic [VTX_CNT_W-1:0] VTX_LAST = VTX_CNT_W'(VTX_PER_QUAD - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_STEP       = 1'd0,
    REG_GLYPH_HEIGHT = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [TEX_W-1:0]    left;
    logic [TEX_W-1:0]    right;
    logic [GWIDTH_W-1:0] width;
  } glyph_t;

  typedef struct packed {
    logic [POS_W-1:0] xl;
    logic [POS_W-1:0] xr;
    logic [TEX_W-1:0] left;
    logic [TEX_W-1:0] right;
  } quad_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
    return s[POS_W] ? PEN_MAX : s[POS_W-1:0];
  endfunction

  // corner order: TL, BR, BL, TL, TR, BR
  function automatic logic vtx_right(input logic [VTX_CNT_W-1:0] k);
    logic r;
    case (k)
      3'd1, 3'd4, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic vtx_bottom(input logic [VTX_CNT_W-1:0] k);
    logic b;
    case (k)
      3'd1, 3'd2, 3'd5: b = 1'b1;
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### sv/gqv_in_if.sv
// ----------------------------------------------------------------------------
// gqv_in_if
// Input word channel: load and render items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gqv_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [gqv_pkg::CODE_W-1:0]     char_code;
  logic                           start_of_text;
  logic [gqv_pkg::TEX_W-1:0]      glyph_left;
  logic [gqv_pkg::TEX_W-1:0]      glyph_right;
  logic [gqv_pkg::GWIDTH_W-1:0]   glyph_width;

  modport source (output valid, operation, char_code, start_of_text, glyph_left,
                  glyph_right, glyph_width, input ready);
  modport sink (input valid, operation, char_code, start_of_text, glyph_left,
                glyph_right, glyph_width, output ready);
endinterface

`default_nettype wire

### sv/gqv_out_if.sv
// ----------------------------------------------------------------------------
// gqv_out_if
// Output word channel: one quad vertex per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gqv_out_if;
  logic                                valid;
  logic                                ready;
  logic [gqv_pkg::POS_W-1:0]           pos_x;
  logic signed [gqv_pkg::HEIGHT_W-1:0] pos_y;
  logic [gqv_pkg::TEX_W-1:0]           tex_u;
  logic                                tex_v;
  logic                                last_vertex;

  modport source (output valid, pos_x, pos_y, tex_u, tex_v, last_vertex, input ready);
  modport sink (input valid, pos_x, pos_y, tex_u, tex_v, last_vertex, output ready);
endinterface

`default_nettype wire

### sv/gqv_front.sv
// ----------------------------------------------------------------------------
// gqv_front
// Accepts words, keeps the glyph table and the pen, builds quad records.
// ----------------------------------------------------------------------------
`default_nettype none

module gqv_front (
  input  logic                        clk,
  input  logic                        rst,
  gqv_in_if.sink                      glyph_in,
  input  logic [gqv_pkg::XSTEP_W-1:0] x_step,
  input  gqv_pkg::fifo_stat_t         fifo_stat,
  output logic                        push,
  output gqv_pkg::quad_t              push_quad
);
  import gqv_pkg::*;

  glyph_t mem [GLYPH_COUNT];
  glyph_t rd_glyph;

  logic [CODE_W-1:0]      offset;
  logic [GLYPH_IDX_W-1:0] idx;
  logic                   hit;
  logic                   accept;
  logic                   is_render;
  logic [FIFO_CNT_W:0]    used;

  logic                   s1_valid;
  logic                   s1_start;
  logic                   s1_hit;
  logic                   s1_space;

  logic                   s2_valid;
  logic                   s2_start;
  logic                   s2_hit;
  logic                   s2_space;
  logic [SIZE_W-1:0]      s2_size;
  logic [TEX_W-1:0]       s2_left;
  logic [TEX_W-1:0]       s2_right;

  logic [GWIDTH_W-1:0]    mul_a;
  logic [SIZE_W-1:0]      size_next;

  logic [POS_W-1:0]       pen;
  logic [POS_W-1:0]       pen_next;
  logic [POS_W-1:0]       base;
  logic [POS_W:0]         sum_r;
  logic [POS_W:0]         sum_a;

  assign offset    = glyph_in.char_code - FIRST_CODE;
  assign idx       = offset[GLYPH_IDX_W-1:0];
  assign hit       = (glyph_in.char_code >= FIRST_CODE) && (glyph_in.char_code <= LAST_CODE) &&
                     (offset < COUNT_CODE);
  assign accept    = glyph_in.valid && glyph_in.ready;
  assign is_render = (op_t'(glyph_in.operation) == OP_RENDER);

  assign used = (FIFO_CNT_W + 1)'(fifo_stat.count) + (FIFO_CNT_W + 1)'(s1_valid) +
                (FIFO_CNT_W + 1)'(s2_valid);
  assign glyph_in.ready = (used < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (accept && !is_render && hit) begin
      mem[idx] <= '{left: glyph_in.glyph_left, right: glyph_in.glyph_right,
                    width: glyph_in.glyph_width};
    end
    if (accept && is_render && hit) begin
      rd_glyph <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && is_render;
    end
    s1_start <= glyph_in.start_of_text;
    s1_hit   <= hit;
    s1_space <= (glyph_in.char_code == FIRST_CODE);
  end

  // space advances by 2 steps here plus the gap step below
  assign mul_a     = s1_space ? SPACE_MUL : rd_glyph.width;
  assign size_next = SIZE_W'(mul_a) * SIZE_W'(x_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_start <= s1_start;
    s2_hit   <= s1_hit;
    s2_space <= s1_space;
    s2_size  <= size_next;
    s2_left  <= rd_glyph.left;
    s2_right <= rd_glyph.right;
  end

  assign base  = s2_start ? '0 : pen;
  assign sum_r = (POS_W + 1)'(base) + (POS_W + 1)'(s2_size);
  assign sum_a = (POS_W + 1)'(base) + (POS_W + 1)'(s2_size) + (POS_W + 1)'(x_step);

  always_comb begin
    pen_next = pen;
    if (s2_valid) begin
      pen_next = s2_hit ? sat_pos(sum_a) : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen <= '0;
    end else begin
      pen <= pen_next;
    end
  end

  assign push      = s2_valid && s2_hit && !s2_space;
  assign push_quad = '{xl: base, xr: sat_pos(sum_r), left: s2_left, right: s2_right};

endmodule

`default_nettype wire

### sv/gqv_fifo.sv
// ----------------------------------------------------------------------------
// gqv_fifo
// Short queue of quad records between the front and the vertex sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gqv_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gqv_pkg::quad_t      push_quad,
  input  logic                pop,
  output gqv_pkg::quad_t      head,
  output gqv_pkg::fifo_stat_t stat
);
  import gqv_pkg::*;

  quad_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

`default_nettype wire

### sv/gqv_back.sv
// ----------------------------------------------------------------------------
// gqv_back
// Vertex sequencer: expands each quad record into six output words.
// ----------------------------------------------------------------------------
`default_nettype none

module gqv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gqv_pkg::HEIGHT_W-1:0] glyph_height,
  input  gqv_pkg::quad_t               head,
  input  gqv_pkg::fifo_stat_t          fifo_stat,
  output logic                         pop,
  gqv_out_if.source                    vertex_out
);
  import gqv_pkg::*;

  quad_t                 cur;
  logic                  cur_valid;
  logic [VTX_CNT_W-1:0]  vcnt;
  logic                  load_out;
  logic                  at_last;
  logic                  is_right;
  logic                  is_bottom;

  logic                  ov;
  logic [POS_W-1:0]      o_x;
  logic [HEIGHT_W-1:0]   o_y;
  logic [TEX_W-1:0]      o_u;
  logic                  o_v;
  logic                  o_last;

  logic [HEIGHT_W-1:0]   h;
  logic [HEIGHT_W-1:0]   neg_h;

  assign h     = (glyph_height > HEIGHT_MAX) ? HEIGHT_MAX : glyph_height;
  assign neg_h = HEIGHT_W'(0) - h;

  assign at_last   = (vcnt == VTX_LAST);
  assign load_out  = cur_valid && (!ov || vertex_out.ready);
  assign pop       = !fifo_stat.empty && (!cur_valid || (load_out && at_last));
  assign is_right  = vtx_right(vcnt);
  assign is_bottom = vtx_bottom(vcnt);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      vcnt      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      vcnt      <= '0;
    end else if (load_out) begin
      if (at_last) begin
        cur_valid <= 1'b0;
      end
      vcnt <= vcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_out) begin
      ov <= 1'b1;
    end else if (vertex_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_x    <= is_right ? cur.xr : cur.xl;
      o_y    <= is_bottom ? neg_h : '0;
      o_u    <= is_right ? cur.right : cur.left;
      o_v    <= is_bottom;
      o_last <= at_last;
    end
  end

  assign vertex_out.valid       = ov;
  assign vertex_out.pos_x       = o_x;
  assign vertex_out.pos_y       = o_y;
  assign vertex_out.tex_u       = o_u;
  assign vertex_out.tex_v       = o_v;
  assign vertex_out.last_vertex = o_last;

endmodule

`default_nettype wire

### sv/glyph_quad_vertex_emitter_unit.sv
// Throughput: one vertex word per cycle while the receiver is ready, set by the vertex
// sequencer; loads, spaces and ignored codes are accepted one per cycle while the quad
// queue has room.
// Reset (rst, synchronous): clears pen, queue, pipeline and output, restores x_step and
// glyph_height; the glyph table keeps its contents and is undefined until loaded.
// ----------------------------------------------------------------------------
// glyph_quad_vertex_emitter_unit
// Bitmap font quad generator: glyph table, pen tracking and vertex output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_quad_vertex_emitter_unit_assert.svh"

module glyph_quad_vertex_emitter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gqv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gqv_pkg::CFG_DATA_W-1:0] cfg_data,
  gqv_in_if.sink                         glyph_in,
  gqv_out_if.source                      vertex_out
);
  import gqv_pkg::*;

  logic [XSTEP_W-1:0]  x_step;
  logic [HEIGHT_W-1:0] glyph_height;

  logic       fifo_push;
  logic       fifo_pop;
  quad_t      push_quad;
  quad_t      head;
  fifo_stat_t fifo_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_step       <= XSTEP_RST;
      glyph_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_X_STEP:       x_step       <= cfg_data[XSTEP_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[HEIGHT_W-1:0];
        default:          ;
      endcase
    end
  end

  gqv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .glyph_in  (glyph_in),
    .x_step    (x_step),
    .fifo_stat (fifo_stat),
    .push      (fifo_push),
    .push_quad (push_quad)
  );

  gqv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_quad (push_quad),
    .pop       (fifo_pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  gqv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .glyph_height (glyph_height),
    .head         (head),
    .fifo_stat    (fifo_stat),
    .pop          (fifo_pop),
    .vertex_out   (vertex_out)
  );

  `GQV_ASSERT_IMPL(a_push_room, clk, rst, fifo_push, !fifo_stat.full)
  `GQV_ASSERT_IMPL(a_pop_data, clk, rst, fifo_pop, !fifo_stat.empty)
  `GQV_ASSERT_IMPL(a_accept_credit, clk, rst, glyph_in.valid && glyph_in.ready, !fifo_stat.full)
  `GQV_ASSERT_NEXT(a_reset_idle, clk, rst, !vertex_out.valid)

endmodule

`default_nettype wire

### bench/gqv_vertex_check.sv
// ----------------------------------------------------------------------------
// gqv_vertex_check
// Watches the glyph and vertex channels and the register port, keeps its own
// glyph table, pen and register copies, predicts the six vertex words of
// every rendered glyph and compares each vertex word field by field.
// ----------------------------------------------------------------------------
module gqv_vertex_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gqv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gqv_pkg::CFG_DATA_W-1:0] cfg_data,
  gqv_in_if                              glyph_in,
  gqv_out_if                             vertex_out,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import gqv_pkg::*;

  localparam int                  CODE_LO       = 32;
  localparam int                  CODE_HI       = 126;
  localparam int                  SPACE_ADVANCE = 3;
  localparam int                  GLYPH_GAP     = 1;
  localparam logic [POS_W-1:0]    PEN_SAT       = 32'hFFFF_FFFF;
  localparam logic [HEIGHT_W-1:0] HEIGHT_CAP    = 26'h200_0000;
  localparam logic [XSTEP_W-1:0]  STEP_AT_RST   = 21'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_AT_RST = 26'd32768;
  localparam int                  PRINT_CAP     = 200;

  typedef struct packed {
    logic [POS_W-1:0]    pos_x;
    logic [HEIGHT_W-1:0] pos_y;
    logic [TEX_W-1:0]    tex_u;
    logic                tex_v;
    logic                last_vertex;
  } vertex_t;

  glyph_t              glyph_mem [GLYPH_COUNT];
  logic [XSTEP_W-1:0]  step_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [POS_W-1:0]    pen_q;
  vertex_t             expected_vertices [$];

  function automatic logic [POS_W-1:0] pen_add(logic [POS_W-1:0] base, logic [63:0] delta);
    logic [64:0] sum;
    sum = {33'd0, base} + {1'b0, delta};
    return (sum > 65'(PEN_SAT)) ? PEN_SAT : sum[POS_W-1:0];
  endfunction

  function automatic vertex_t corner(logic [POS_W-1:0] x, logic bottom, logic [TEX_W-1:0] u,
                                     logic [HEIGHT_W-1:0] h, logic last);
    vertex_t v;
    v.pos_x       = x;
    v.pos_y       = bottom ? HEIGHT_W'(0) - h : '0;
    v.tex_u       = u;
    v.tex_v       = bottom;
    v.last_vertex = last;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: vertex %s mismatch, expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    vertex_t             got;
    vertex_t             want;
    glyph_t              g;
    int                  code;
    logic                known;
    logic [63:0]         span;
    logic [POS_W-1:0]    xl;
    logic [POS_W-1:0]    xr;
    logic [HEIGHT_W-1:0] h;
    if (rst) begin
      step_q   = STEP_AT_RST;
      height_q = HEIGHT_AT_RST;
      pen_q    = '0;
      expected_vertices.delete();
      mismatches = 0;
    end else begin
      if (vertex_out.valid && vertex_out.ready) begin
        got.pos_x       = vertex_out.pos_x;
        got.pos_y       = vertex_out.pos_y;
        got.tex_u       = vertex_out.tex_u;
        got.tex_v       = vertex_out.tex_v;
        got.last_vertex = vertex_out.last_vertex;
        if (expected_vertices.size() == 0) begin
          report_mismatch("word with none pending, pos_x", '0, got.pos_x);
        end else begin
          want = expected_vertices.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", want.pos_y, got.pos_y);
          if (got.tex_u !== want.tex_u) report_mismatch("tex_u", want.tex_u, got.tex_u);
          if (got.tex_v !== want.tex_v) report_mismatch("tex_v", want.tex_v, got.tex_v);
          if (got.last_vertex !== want.last_vertex)
            report_mismatch("last_vertex", want.last_vertex, got.last_vertex);
        end
      end

      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_X_STEP:       step_q = cfg_data[XSTEP_W-1:0];
          REG_GLYPH_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end

      if (glyph_in.valid && glyph_in.ready) begin
        code  = int'(glyph_in.char_code);
        known = (code >= CODE_LO) && (code <= CODE_HI) && (code - CODE_LO < GLYPH_COUNT);
        if (op_t'(glyph_in.operation) == OP_LOAD) begin
          if (known)
            glyph_mem[code - CODE_LO] = '{left: glyph_in.glyph_left,
                                          right: glyph_in.glyph_right,
                                          width: glyph_in.glyph_width};
        end else begin
          if (glyph_in.start_of_text) pen_q = '0;
          if (known && code == CODE_LO) begin
            pen_q = pen_add(pen_q, 64'(step_q) * SPACE_ADVANCE);
          end else if (known) begin
            g    = glyph_mem[code - CODE_LO];
            span = 64'(g.width) * 64'(step_q);
            xl   = pen_q;
            xr   = pen_add(pen_q, span);
            h    = (height_q > HEIGHT_CAP) ? HEIGHT_CAP : height_q;
            expected_vertices.push_back(corner(xl, 1'b0, g.left,  h, 1'b0));
            expected_vertices.push_back(corner(xr, 1'b1, g.right, h, 1'b0));
            expected_vertices.push_back(corner(xl, 1'b1, g.left,  h, 1'b0));
            expected_vertices.push_back(corner(xl, 1'b0, g.left,  h, 1'b0));
            expected_vertices.push_back(corner(xr, 1'b0, g.right, h, 1'b0));
            expected_vertices.push_back(corner(xr, 1'b1, g.right, h, 1'b1));
            pen_q = pen_add(pen_q, span + 64'(step_q) * GLYPH_GAP);
          end
        end
      end
    end
    outstanding = expected_vertices.size();
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives glyph loads, render words and register settings into the glyph quad
// vertex emitter under random sender and receiver idling, and reports the
// verdict from the vertex checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gqv_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 20;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle_pct = 24;
  int recv_idle_pct = 86;
  bit hold_req      = 1'b0;
  int idle_cycles   = 0;
  int mismatches;
  int outstanding;

  gqv_in_if  glyph_in ();
  gqv_out_if vertex_out ();

  glyph_quad_vertex_emitter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .glyph_in   (glyph_in),
    .vertex_out (vertex_out)
  );

  gqv_vertex_check vertex_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .glyph_in    (glyph_in),
    .vertex_out  (vertex_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CODE_W-1:0] stray_code();
    return $urandom_range(1) ? CODE_W'($urandom_range(31, 0))
                             : CODE_W'($urandom_range(255, 127));
  endfunction

  task automatic send_word(op_t op, logic [CODE_W-1:0] code, logic sot,
                           logic [TEX_W-1:0] u_left, logic [TEX_W-1:0] u_right,
                           logic [GWIDTH_W-1:0] px);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      glyph_in.valid <= 1'b0;
      @(posedge clk);
    end
    glyph_in.valid         <= 1'b1;
    glyph_in.operation     <= op;
    glyph_in.char_code     <= code;
    glyph_in.start_of_text <= sot;
    glyph_in.glyph_left    <= u_left;
    glyph_in.glyph_right   <= u_right;
    glyph_in.glyph_width   <= px;
    do begin
      @(negedge clk);
      took = glyph_in.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic load_glyph(logic [CODE_W-1:0] code, logic [TEX_W-1:0] u_left,
                            logic [TEX_W-1:0] u_right, logic [GWIDTH_W-1:0] px);
    send_word(OP_LOAD, code, 1'($urandom_range(1)), u_left, u_right, px);
  endtask

  task automatic render(logic [CODE_W-1:0] code, logic sot);
    send_word(OP_RENDER, code, sot, TEX_W'($urandom_range(65535, 0)),
              TEX_W'($urandom_range(65535, 0)), GWIDTH_W'($urandom_range(255, 0)));
  endtask

  // hold input until every vertex is out, then let loads and spaces finish
  task automatic settle();
    glyph_in.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] height);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_X_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_GLYPH_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int                pick;
    logic [CODE_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 22) begin
      c = CODE_W'($urandom_range(126, 32));
      load_glyph(c, TEX_W'($urandom_range(65535, 0)), TEX_W'($urandom_range(65535, 0)),
                 ($urandom_range(7) == 0) ? 8'hFF : GWIDTH_W'($urandom_range(255, 0)));
    end else if (pick < 27) begin
      load_glyph(stray_code(), TEX_W'($urandom_range(65535, 0)),
                 TEX_W'($urandom_range(65535, 0)), GWIDTH_W'($urandom_range(255, 0)));
    end else if (pick < 92) begin
      c = ($urandom_range(9) == 0) ? 8'd32 : CODE_W'($urandom_range(126, 33));
      render(c, $urandom_range(99) < 8);
    end else begin
      render(stray_code(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    vertex_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        vertex_out.ready <= 1'b0;
        hold_left--;
      end else begin
        vertex_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (glyph_in.valid && glyph_in.ready) ||
        (vertex_out.valid && vertex_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    glyph_in.valid         <= 1'b0;
    glyph_in.operation     <= OP_LOAD;
    glyph_in.char_code     <= '0;
    glyph_in.start_of_text <= 1'b0;
    glyph_in.glyph_left    <= '0;
    glyph_in.glyph_right   <= '0;
    glyph_in.glyph_width   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    load_glyph(8'd32, 16'h1357, 16'h2468, 8'd5);
    load_glyph(8'd33, 16'h0000, 16'hFFFF, 8'd0);
    load_glyph(8'd126, 16'hFFFF, 16'h0000, 8'hFF);
    load_glyph(8'd31, 16'hAAAA, 16'h5555, 8'h0F);
    load_glyph(8'd127, 16'h5555, 16'hAAAA, 8'hF0);
    load_glyph(8'd255, 16'hFFFF, 16'hFFFF, 8'hFF);
    load_glyph(8'd0, 16'h0000, 16'h0000, 8'h00);
    render(8'd33, 1'b1);
    render(8'd126, 1'b0);
    render(8'd32, 1'b0);
    render(8'd126, 1'b0);
    render(8'd31, 1'b1);
    render(8'd126, 1'b0);
    render(8'd127, 1'b0);
    render(8'd255, 1'b1);
    render(8'd32, 1'b1);
    render(8'd33, 1'b0);
    load_glyph(8'd126, 16'h1234, 16'hABCD, 8'd1);
    render(8'd126, 1'b0);
    render(8'd0, 1'b0);

    for (int c = 32; c <= 126; c++)
      load_glyph(CODE_W'(c), TEX_W'($urandom_range(65535, 0)),
                 TEX_W'($urandom_range(65535, 0)), GWIDTH_W'($urandom_range(255, 0)));

    set_regs(CFG_DATA_W'(1), CFG_DATA_W'(0));
    repeat (70) random_item();

    send_idle_pct = 86;
    recv_idle_pct = 24;
    set_regs(CFG_DATA_W'(1048576), 26'h3FF_FFFF);
    load_glyph(8'd126, TEX_W'($urandom_range(65535, 0)), TEX_W'($urandom_range(65535, 0)),
               8'hFF);
    // drive the pen into saturation
    repeat (20) render(8'd126, 1'b0);
    render(8'd32, 1'b0);
    repeat (60) random_item();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(CFG_DATA_W'(0), 26'h200_0000);
    hold_req = 1'b1;
    repeat (30) render(CODE_W'($urandom_range(126, 33)), 1'b0);
    repeat (25) random_item();

    repeat (2) begin
      set_regs(CFG_DATA_W'($urandom_range(1048576, 1)),
               CFG_DATA_W'($urandom_range(33554432, 0)));
      repeat (30) random_item();
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
